>>> rtl/hkv_pkg.sv
// hkv_pkg: shared types and constants for the hall key press velocity tracker
// depends on nothing; used by every module of the block except hkv_fifo
package hkv_pkg;

	localparam int IDX_W      = 4;
	localparam int SMP_W      = 12;
	localparam int TS_W       = 32;
	localparam int VAL_W      = 7;
	localparam int LAST_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// shared divider geometry
	localparam int DV_NUM_W = 24;
	localparam int DV_DEN_W = 16;
	localparam int DV_CNT_W = 5;

	// depth of the job queue and the result queue
	localparam int Q_DEPTH = 2;

	localparam logic [VAL_W-1:0]  VAL_MAX  = 7'd127;
	localparam logic [SMP_W-1:0]  SMP_MAX  = 12'hfff;
	localparam logic [LAST_W-1:0] LAST_RST = 16'hffff;
	localparam logic [3:0]        NUM_TEN  = 4'd10;

	// x / 10 as (x * 52429) >> 19, exact for x below 43690
	localparam logic [15:0] RECIP_TENTH = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_NUM   = 3'd0,
		REG_RELEASE_NUM = 3'd1,
		REG_DETENT_DIV  = 3'd2,
		REG_VEL_MIN     = 3'd3,
		REG_VEL_MAX     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]  press_numerator;
		logic [3:0]  release_numerator;
		logic [7:0]  detent_divisor;
		logic [15:0] velocity_min_us;
		logic [15:0] velocity_max_us;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] sensor_index;
		logic [SMP_W-1:0] adc_raw;
		logic [SMP_W-1:0] calibrated_sample;
		logic [SMP_W-1:0] cal_min;
		logic [SMP_W-1:0] cal_max;
		logic             sample_valid;
		logic [TS_W-1:0]  time_us;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [SMP_W-1:0] out_raw;
		logic [VAL_W-1:0] travel_value;
		logic [VAL_W-1:0] velocity;
		logic             pressed;
		logic [TS_W-1:0]  change_time_us;
		logic [SMP_W-1:0] press_threshold;
		logic [SMP_W-1:0] release_threshold;
	} out_item_t;

	// accepted sample handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [SMP_W-1:0] raw;
		logic [SMP_W-1:0] cal;
		logic [SMP_W-1:0] cmin;
		logic [SMP_W-1:0] cmax;
		logic [TS_W-1:0]  now;
	} job_t;

endpackage

>>> rtl/hkv_fifo.sv
// hkv_fifo: small register queue with full/empty flags, any payload type
// depends on nothing
module hkv_fifo #(
	parameter int DEPTH = 2,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/hkv_front.sv
// hkv_front: accepts samples, drops invalid or out-of-range ones, queues jobs
// depends on hkv_pkg and hkv_fifo
module hkv_front #(
	parameter int NUM_SENSORS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hkv_pkg::in_item_t sample,
	output logic              job_empty,
	input  logic              job_pop,
	output hkv_pkg::job_t     job
);
	import hkv_pkg::*;

	logic q_full;
	logic keep;
	job_t job_in;

	// classify: only valid samples for an existing sensor become jobs
	assign keep = sample.sample_valid && (32'(sample.sensor_index) < NUM_SENSORS);
	assign full = q_full;

	always_comb begin
		job_in.idx  = sample.sensor_index;
		job_in.raw  = sample.adc_raw;
		job_in.cal  = sample.calibrated_sample;
		job_in.cmin = sample.cal_min;
		job_in.cmax = sample.cal_max;
		job_in.now  = sample.time_us;
	end

	hkv_fifo #(.DEPTH(Q_DEPTH), .T(job_t)) u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.din   (job_in),
		.full  (q_full),
		.pop   (job_pop),
		.dout  (job),
		.empty (job_empty)
	);

endmodule

>>> rtl/hkv_div.sv
// hkv_div: restoring divider, one quotient bit per cycle
// depends on hkv_pkg
module hkv_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [hkv_pkg::DV_NUM_W-1:0] num,
	input  logic [hkv_pkg::DV_DEN_W-1:0] den,
	output logic                          done,
	output logic [hkv_pkg::DV_NUM_W-1:0] quo
);
	import hkv_pkg::*;

	logic [DV_DEN_W-1:0] rem_q;
	logic [DV_DEN_W-1:0] den_q;
	logic [DV_NUM_W-1:0] quo_q;
	logic [DV_CNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DV_DEN_W:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[DV_NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DV_DEN_W'(trial - {1'b0, den_q}) : DV_DEN_W'(trial);
			quo_q <= {quo_q[DV_NUM_W-2:0], fits};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DV_CNT_W'(DV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/hkv_back.sv
// hkv_back: per-sensor state and the sequencer that computes one result per job
// depends on hkv_pkg and hkv_div
module hkv_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	output logic               job_pop,
	input  hkv_pkg::job_t      job,
	input  hkv_pkg::cfg_t      cfg,
	input  logic               res_full,
	output logic               res_push,
	output hkv_pkg::out_item_t res
);
	import hkv_pkg::*;

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_MUL, S_PTH, S_RTH, S_WID, S_DET,
		S_NLO, S_NHI, S_INT, S_BASE, S_VEL, S_VDIV, S_WB
	} state_t;

	// per-sensor state
	logic [SMP_W-1:0]  trk_min_q   [DEPTH];
	logic [SMP_W-1:0]  trk_max_q   [DEPTH];
	logic [LAST_W-1:0] last_q      [DEPTH];
	logic [VAL_W-1:0]  held_vel_q  [DEPTH];
	logic              press_q     [DEPTH];
	logic [TS_W-1:0]   chg_time_q  [DEPTH];
	logic              armed_q     [DEPTH];
	logic [TS_W-1:0]   start_q     [DEPTH];

	state_t            state_q;
	job_t              job_q;
	logic [SW-1:0]     sel;
	logic [SMP_W-1:0]  lo_q, hi_q, rng_q;
	logic [3:0]        pn_q, rn_q;
	logic [15:0]       pm_q, rm_q;
	logic [SMP_W-1:0]  pth_q, rth_q, width_q, dlo_q, dhi_q;
	logic [VAL_W-1:0]  nlo_q, nhi_q, travel_q, vel_q;
	logic              arm_n_q, pr_q;
	logic [TS_W-1:0]   start_n_q, chg_n_q;
	logic              pend_q;
	logic              dv_go_q;
	logic [DV_NUM_W-1:0] dv_num_q;
	logic [DV_DEN_W-1:0] dv_den_q;
	logic              dv_done;
	logic [DV_NUM_W-1:0] dv_quo;
	logic              wb_fire;

	// envelope widening
	logic [SMP_W-1:0]  lo_c, hi_c, rng_c;
	// thresholds
	logic [31:0]       pq_c, rq_c;
	logic [SMP_W:0]    pth_c, rth_c;
	// detent
	logic [SMP_W-1:0]  half_c;
	logic [SMP_W:0]    centre_c, dlo_c;
	logic [SMP_W+1:0]  dhi_c;
	logic              interp_c;
	// velocity
	logic [TS_W-1:0]   dt_c;
	logic [15:0]       dtc_c;

	assign sel = job_q.idx[SW-1:0];

	hkv_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (dv_go_q),
		.num   (dv_num_q),
		.den   (dv_den_q),
		.done  (dv_done),
		.quo   (dv_quo)
	);

	// widen the envelope with the calibrator's bounds
	always_comb begin
		lo_c = (job_q.cmin < trk_min_q[sel]) ? job_q.cmin : trk_min_q[sel];
		hi_c = (job_q.cmax > trk_max_q[sel]) ? job_q.cmax : trk_max_q[sel];
		if (hi_c < lo_c) begin
			hi_c = lo_c;
		end
		rng_c = hi_c - lo_c;
		if (rng_c == '0) begin
			rng_c = SMP_W'(1);
		end
	end

	// press and release thresholds
	always_comb begin
		pq_c  = 32'(pm_q) * 32'(RECIP_TENTH);
		rq_c  = 32'(rm_q) * 32'(RECIP_TENTH);
		pth_c = {1'b0, lo_q} + (SMP_W+1)'(pq_c >> RECIP_SHIFT);
		if (pth_c > {1'b0, SMP_MAX}) begin
			pth_c = {1'b0, SMP_MAX};
		end
		rth_c = {1'b0, lo_q} + (SMP_W+1)'(rq_c >> RECIP_SHIFT);
		if (rth_c <= {1'b0, pth_q}) begin
			rth_c = {1'b0, pth_q} + 1'b1;
		end
		if (rth_c > {1'b0, hi_q}) begin
			rth_c = {1'b0, hi_q};
		end
		if (rth_c < {1'b0, pth_q}) begin
			rth_c = {1'b0, pth_q};
		end
	end

	// detent window around the centre of the range
	always_comb begin
		half_c   = width_q >> 1;
		centre_c = {1'b0, lo_q} + (SMP_W+1)'(rng_q >> 1);
		dlo_c    = (centre_c > {1'b0, half_c}) ? centre_c - {1'b0, half_c} : {1'b0, lo_q};
		dhi_c    = {1'b0, centre_c} + (SMP_W+2)'(half_c);
		if (dhi_c > (SMP_W+2)'(hi_q)) begin
			dhi_c = (SMP_W+2)'(hi_q);
		end
		if (dlo_c < {1'b0, lo_q}) begin
			dlo_c = {1'b0, lo_q};
		end
		if ((SMP_W+2)'(dlo_c) > dhi_c) begin
			dlo_c = (SMP_W+1)'(dhi_c);
		end
		interp_c = ((SMP_W+1)'(job_q.cal) > dlo_c) && ((SMP_W+2)'(job_q.cal) < dhi_c);
	end

	// stroke time, clamped to the configured window
	always_comb begin
		dt_c = job_q.now - start_q[sel];
		if (dt_c < TS_W'(cfg.velocity_min_us)) begin
			dtc_c = cfg.velocity_min_us;
		end else if (dt_c > TS_W'(cfg.velocity_max_us)) begin
			dtc_c = cfg.velocity_max_us;
		end else begin
			dtc_c = dt_c[15:0];
		end
	end

	assign job_pop  = (state_q == S_IDLE) && !job_empty;
	assign wb_fire  = (state_q == S_WB) && !res_full;
	assign res_push = wb_fire;

	always_comb begin
		res.out_index         = job_q.idx;
		res.out_raw           = job_q.raw;
		res.travel_value      = travel_q;
		res.velocity          = vel_q;
		res.pressed           = pr_q;
		res.change_time_us    = chg_n_q;
		res.press_threshold   = pth_q;
		res.release_threshold = rth_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			dv_go_q <= 1'b0;
		end else begin
			dv_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!job_empty) begin
						job_q   <= job;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					lo_q    <= lo_c;
					hi_q    <= hi_c;
					rng_q   <= rng_c;
					pn_q    <= (cfg.press_numerator > NUM_TEN) ? NUM_TEN : cfg.press_numerator;
					rn_q    <= (cfg.release_numerator > NUM_TEN) ? NUM_TEN
						: cfg.release_numerator;
					state_q <= S_MUL;
				end
				S_MUL: begin
					pm_q    <= 16'(rng_q) * 16'(pn_q);
					rm_q    <= 16'(rng_q) * 16'(rn_q);
					state_q <= S_PTH;
				end
				S_PTH: begin
					pth_q   <= pth_c[SMP_W-1:0];
					state_q <= S_RTH;
				end
				S_RTH: begin
					rth_q   <= rth_c[SMP_W-1:0];
					state_q <= S_WID;
				end
				S_WID: begin
					if (!pend_q) begin
						dv_go_q  <= 1'b1;
						dv_num_q <= DV_NUM_W'(rng_q);
						dv_den_q <= (cfg.detent_divisor == '0) ? DV_DEN_W'(1)
							: DV_DEN_W'(cfg.detent_divisor);
						pend_q   <= 1'b1;
					end else if (dv_done) begin
						pend_q  <= 1'b0;
						width_q <= (dv_quo == '0) ? SMP_W'(1) : dv_quo[SMP_W-1:0];
						state_q <= S_DET;
					end
				end
				S_DET: begin
					dlo_q <= dlo_c[SMP_W-1:0];
					dhi_q <= dhi_c[SMP_W-1:0];
					if (interp_c) begin
						state_q <= S_NLO;
					end else if (job_q.cal > hi_q) begin
						// above the envelope: no travel
						travel_q <= '0;
						state_q  <= S_VEL;
					end else begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					if (!pend_q) begin
						dv_go_q  <= 1'b1;
						dv_num_q <= DV_NUM_W'({hi_q - job_q.cal, 7'b0})
							- DV_NUM_W'(hi_q - job_q.cal);
						dv_den_q <= DV_DEN_W'(rng_q);
						pend_q   <= 1'b1;
					end else if (dv_done) begin
						pend_q   <= 1'b0;
						travel_q <= (dv_quo > DV_NUM_W'(VAL_MAX)) ? VAL_MAX
							: dv_quo[VAL_W-1:0];
						state_q  <= S_VEL;
					end
				end
				S_NLO: begin
					if (!pend_q) begin
						dv_go_q  <= 1'b1;
						dv_num_q <= DV_NUM_W'({hi_q - dlo_q, 7'b0}) - DV_NUM_W'(hi_q - dlo_q);
						dv_den_q <= DV_DEN_W'(rng_q);
						pend_q   <= 1'b1;
					end else if (dv_done) begin
						pend_q  <= 1'b0;
						nlo_q   <= dv_quo[VAL_W-1:0];
						state_q <= S_NHI;
					end
				end
				S_NHI: begin
					if (!pend_q) begin
						dv_go_q  <= 1'b1;
						dv_num_q <= DV_NUM_W'({hi_q - dhi_q, 7'b0}) - DV_NUM_W'(hi_q - dhi_q);
						dv_den_q <= DV_DEN_W'(rng_q);
						pend_q   <= 1'b1;
					end else if (dv_done) begin
						pend_q  <= 1'b0;
						nhi_q   <= dv_quo[VAL_W-1:0];
						state_q <= S_INT;
					end
				end
				S_INT: begin
					// linear step across the detent, falling from nlo toward nhi
					if (!pend_q) begin
						dv_go_q  <= 1'b1;
						dv_num_q <= DV_NUM_W'(nlo_q - nhi_q) * DV_NUM_W'(job_q.cal - dlo_q);
						dv_den_q <= DV_DEN_W'(dhi_q - dlo_q);
						pend_q   <= 1'b1;
					end else if (dv_done) begin
						pend_q   <= 1'b0;
						travel_q <= nlo_q - dv_quo[VAL_W-1:0];
						state_q  <= S_VEL;
					end
				end
				S_VEL: begin
					arm_n_q   <= armed_q[sel];
					start_n_q <= start_q[sel];
					vel_q     <= held_vel_q[sel];
					state_q   <= S_WB;
					if (!armed_q[sel]) begin
						if (last_q[sel] > LAST_W'(rth_q) && job_q.cal <= rth_q) begin
							start_n_q <= job_q.now;
							arm_n_q   <= 1'b1;
						end
					end else if (job_q.cal > rth_q) begin
						arm_n_q <= 1'b0;
					end else if (job_q.cal <= pth_q) begin
						arm_n_q <= 1'b0;
						if (cfg.velocity_max_us <= cfg.velocity_min_us) begin
							vel_q <= (dt_c <= TS_W'(cfg.velocity_min_us)) ? VAL_MAX : '0;
						end else begin
							dv_go_q  <= 1'b1;
							dv_num_q <= DV_NUM_W'({cfg.velocity_max_us - dtc_c, 7'b0})
								- DV_NUM_W'(cfg.velocity_max_us - dtc_c);
							dv_den_q <= cfg.velocity_max_us - cfg.velocity_min_us;
							state_q  <= S_VDIV;
						end
					end
					// press state with hysteresis
					if (job_q.cal <= pth_q) begin
						pr_q <= 1'b1;
					end else if (job_q.cal >= rth_q) begin
						pr_q <= 1'b0;
					end else begin
						pr_q <= press_q[sel];
					end
					chg_n_q <= chg_time_q[sel];
					if ((job_q.cal <= pth_q && !press_q[sel])
						|| (job_q.cal > pth_q && job_q.cal >= rth_q && press_q[sel])) begin
						chg_n_q <= job_q.now;
					end
				end
				S_VDIV: begin
					if (dv_done) begin
						vel_q   <= (dv_quo > DV_NUM_W'(VAL_MAX)) ? VAL_MAX : dv_quo[VAL_W-1:0];
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-sensor state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				trk_min_q[i]  <= SMP_MAX;
				trk_max_q[i]  <= '0;
				last_q[i]     <= LAST_RST;
				held_vel_q[i] <= '0;
				press_q[i]    <= 1'b0;
				chg_time_q[i] <= '0;
				armed_q[i]    <= 1'b0;
				start_q[i]    <= '0;
			end
		end else if (wb_fire) begin
			trk_min_q[sel]  <= lo_q;
			trk_max_q[sel]  <= hi_q;
			last_q[sel]     <= LAST_W'(job_q.cal);
			held_vel_q[sel] <= vel_q;
			press_q[sel]    <= pr_q;
			chg_time_q[sel] <= chg_n_q;
			armed_q[sel]    <= arm_n_q;
			start_q[sel]    <= start_n_q;
		end
	end

endmodule

>>> rtl/hall_key_press_velocity_tracker.sv
// Hall key press velocity tracker. Each sample runs through the sequencer
// states, with a pass of the shared serial divider for the detent width,
// one more pass for the travel value outside the detent (none when the
// sample lies above the envelope) or three inside it, and a pass when a
// stroke completes and velocity_max_us exceeds velocity_min_us. Two samples
// wait in the input queue and two results in the output queue, so both sides
// may stall independently. Samples that are not valid or whose sensor index
// is NUM_SENSORS or more are accepted and dropped.
// Depends on hkv_pkg, hkv_front, hkv_back and hkv_fifo.
module hall_key_press_velocity_tracker #(
	parameter int NUM_SENSORS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  hkv_pkg::in_item_t               sample,
	output logic                            empty,
	input  logic                            pop,
	output hkv_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hkv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hkv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hkv_pkg::*;

	localparam int DEPTH = (NUM_SENSORS < 16) ? NUM_SENSORS : 16;

	cfg_t      cfg_q;
	job_t      job;
	logic      job_empty;
	logic      job_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_numerator   <= 4'd4;
			cfg_q.release_numerator <= 4'd6;
			cfg_q.detent_divisor    <= 8'd20;
			cfg_q.velocity_min_us   <= 16'd500;
			cfg_q.velocity_max_us   <= 16'd30000;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESS_NUM:   cfg_q.press_numerator   <= cfg_data[3:0];
				REG_RELEASE_NUM: cfg_q.release_numerator <= cfg_data[3:0];
				REG_DETENT_DIV:  cfg_q.detent_divisor    <= cfg_data[7:0];
				REG_VEL_MIN:     cfg_q.velocity_min_us   <= cfg_data;
				REG_VEL_MAX:     cfg_q.velocity_max_us   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hkv_front #(.NUM_SENSORS(NUM_SENSORS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.job      (job)
	);

	hkv_back #(.DEPTH(DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.job      (job),
		.cfg      (cfg_q),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue
	hkv_fifo #(.DEPTH(Q_DEPTH), .T(out_item_t)) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

>>> tb/tb.sv
// tb: self-checking bench for hall_key_press_velocity_tracker
// depends on hkv_pkg and the tracker rtl; a bit-true key model predicts every result
module tb;
	import hkv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	in_item_t sample = '0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	hall_key_press_velocity_tracker dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// item queues and bookkeeping
	in_item_t sample_q[$];
	out_item_t key_q[$];
	int errors = 0;
	bit calm = 1'b0;
	int unsigned tnow = 32'd1000;

	// shadow configuration
	int unsigned k_pn = 4, k_rn = 6, k_div = 20, k_vmin = 500, k_vmax = 30000;

	// shadow per-key state
	int unsigned k_min[16], k_max[16], k_last[16], k_vel[16], k_chg[16], k_start[16];
	bit k_prs[16], k_arm[16];

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 3_000_000);
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned sat7(int v);
		if (v < 0) return 0;
		if (v > 127) return 127;
		return v;
	endfunction

	// travel position with linear interpolation across the detent
	function automatic int unsigned travel_est(int v, int lo, int hi, int dlo, int dhi);
		int rng, base, nlo, nhi;
		if (dlo < lo) dlo = lo;
		if (dhi > hi) dhi = hi;
		if (dlo > dhi) dlo = dhi;
		rng = hi - lo;
		if (rng <= 0) rng = 1;
		base = (hi - v) * 127 / rng;
		if (v <= dlo || dlo == dhi || v >= dhi) return sat7(base);
		nlo = (hi - dlo) * 127 / rng;
		nhi = (hi - dhi) * 127 / rng;
		return sat7(nlo + (nhi - nlo) * (v - dlo) / (dhi - dlo));
	endfunction

	// advance one key and build its expected result
	function automatic bit key_predict(input in_item_t s, output out_item_t r);
		int unsigned i, cal, lo, hi, rng, pn, rn, dv, pth, rth, wd, ctr, dlo, dhi, vel, dt;
		int unsigned cmin, cmax;
		bit pr;
		r = '0;
		if (!s.sample_valid) return 1'b0;
		i = 32'(s.sensor_index);
		cal = 32'(s.calibrated_sample);
		cmin = 32'(s.cal_min);
		cmax = 32'(s.cal_max);
		lo = k_min[i];
		hi = k_max[i];
		if (cmin < lo) lo = cmin;
		if (cmax > hi) hi = cmax;
		if (hi < lo) hi = lo;
		rng = hi - lo;
		if (rng == 0) rng = 1;
		pn = k_pn > 10 ? 10 : k_pn;
		rn = k_rn > 10 ? 10 : k_rn;
		pth = lo + rng * pn / 10;
		if (pth > 4095) pth = 4095;
		rth = lo + rng * rn / 10;
		if (rth <= pth) rth = pth + 1;
		if (rth > hi) rth = hi;
		if (rth < pth) rth = pth;
		dv = k_div == 0 ? 1 : k_div;
		wd = rng / dv;
		if (wd == 0) wd = 1;
		ctr = lo + rng / 2;
		dlo = (ctr > wd / 2) ? ctr - wd / 2 : lo;
		dhi = ctr + wd / 2;
		if (dhi > hi) dhi = hi;
		// stroke timing between the two thresholds
		vel = k_vel[i];
		if (!k_arm[i]) begin
			if (k_last[i] > rth && cal <= rth) begin
				k_start[i] = s.time_us;
				k_arm[i] = 1'b1;
			end
		end else if (cal > rth) begin
			k_arm[i] = 1'b0;
		end else if (cal <= pth) begin
			dt = s.time_us - k_start[i];
			if (k_vmax <= k_vmin) begin
				vel = (dt <= k_vmin) ? 127 : 0;
			end else begin
				if (dt < k_vmin) dt = k_vmin;
				if (dt > k_vmax) dt = k_vmax;
				vel = (k_vmax - dt) * 127 / (k_vmax - k_vmin);
				if (vel > 127) vel = 127;
			end
			k_arm[i] = 1'b0;
		end
		// press state with hysteresis
		pr = k_prs[i];
		if (cal <= pth) pr = 1'b1;
		else if (cal >= rth) pr = 1'b0;
		if (pr != k_prs[i]) k_chg[i] = s.time_us;
		k_min[i] = lo;
		k_max[i] = hi;
		k_vel[i] = vel;
		k_prs[i] = pr;
		k_last[i] = cal;
		r.out_index = s.sensor_index;
		r.out_raw = s.adc_raw;
		r.travel_value = 7'(travel_est(cal, lo, hi, dlo, dhi));
		r.velocity = 7'(vel);
		r.pressed = pr;
		r.change_time_us = k_chg[i];
		r.press_threshold = 12'(pth);
		r.release_threshold = 12'(rth);
		return 1'b1;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// driver: offer the next item at the falling edge
	always @(negedge clk) begin
		if (arst_n && sample_q.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
			push <= 1'b1;
			sample <= sample_q[0];
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && (calm || $urandom_range(0, 99) >= 17);
	end

	// accepted item: predict it
	always @(posedge clk) begin
		out_item_t r;
		if (push && !full) begin
			if (key_predict(sample_q[0], r)) key_q.push_back(r);
			void'(sample_q.pop_front());
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t w;
		if (pop && !empty) begin
			if (key_q.size() == 0) begin
				report("unexpected item", result.out_index, -1);
			end else begin
				w = key_q.pop_front();
				if (result.out_index !== w.out_index)
					report("out_index", result.out_index, w.out_index);
				if (result.out_raw !== w.out_raw) report("out_raw", result.out_raw, w.out_raw);
				if (result.travel_value !== w.travel_value)
					report("travel_value", result.travel_value, w.travel_value);
				if (result.velocity !== w.velocity)
					report("velocity", result.velocity, w.velocity);
				if (result.pressed !== w.pressed) report("pressed", result.pressed, w.pressed);
				if (result.change_time_us !== w.change_time_us)
					report("change_time_us", result.change_time_us, w.change_time_us);
				if (result.press_threshold !== w.press_threshold)
					report("press_threshold", result.press_threshold, w.press_threshold);
				if (result.release_threshold !== w.release_threshold)
					report("release_threshold", result.release_threshold, w.release_threshold);
			end
		end
	end

	task automatic add_sample(int idx, int raw, int cal, int cmin, int cmax, bit v, int unsigned t);
		in_item_t s;
		s.sensor_index = 4'(idx);
		s.adc_raw = 12'(raw);
		s.calibrated_sample = 12'(cal);
		s.cal_min = 12'(cmin);
		s.cal_max = 12'(cmax);
		s.sample_valid = v;
		s.time_us = t;
		sample_q.push_back(s);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(reg_idx_t ri, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= 16'(val);
		do @(posedge clk); while (!cfg_ready);
		case (ri)
			REG_PRESS_NUM:   k_pn = val & 4'hf;
			REG_RELEASE_NUM: k_rn = val & 4'hf;
			REG_DETENT_DIV:  k_div = val & 8'hff;
			REG_VEL_MIN:     k_vmin = val & 16'hffff;
			REG_VEL_MAX:     k_vmax = val & 16'hffff;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(int pn, int rn, int dv, int vmin, int vmax);
		write_reg(REG_PRESS_NUM, pn);
		write_reg(REG_RELEASE_NUM, rn);
		write_reg(REG_DETENT_DIV, dv);
		write_reg(REG_VEL_MIN, vmin);
		write_reg(REG_VEL_MAX, vmax);
	endtask

	task automatic drain();
		wait (sample_q.size() == 0 && key_q.size() == 0);
		repeat (400) @(posedge clk);
	endtask

	// mostly press strokes with random content, the rest noise
	task automatic random_items(int n);
		int k, j, steps, idx, lo, hi;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 99) < 25) begin
				add_sample($urandom_range(0, 15), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 3) != 0, $urandom());
				k++;
			end else begin
				idx = $urandom_range(0, 15);
				lo = $urandom_range(0, 800);
				hi = $urandom_range(2800, 4095);
				steps = $urandom_range(2, 6);
				if ($urandom_range(0, 19) == 0) tnow = 32'hffff_f000 + $urandom_range(0, 4000);
				for (j = 0; j <= 2 * steps; j++) begin
					tnow += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
						: $urandom_range(0, 5000);
					add_sample(idx, $urandom_range(0, 4095),
						(j <= steps) ? hi - (hi - lo) * j / steps + $urandom_range(0, 40)
						: lo + (hi - lo) * (j - steps) / steps, lo + $urandom_range(0, 60),
						hi - $urandom_range(0, 60), 1'b1, tnow);
					k++;
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 16; i++) begin
			k_min[i] = 4095; k_max[i] = 0; k_last[i] = 65535; k_vel[i] = 0;
			k_prs[i] = 0; k_chg[i] = 0; k_arm[i] = 0; k_start[i] = 0;
		end
		// directed: extremes, full stroke, detent, invalid, degenerate range, time wrap
		add_sample(15, 4095, 4095, 0, 4095, 1'b1, 32'hffff_ff00);
		add_sample(15, 0, 3000, 0, 4095, 1'b1, 32'hffff_ff80);
		add_sample(15, 4095, 2048, 0, 4095, 1'b1, 32'h0000_0010);
		add_sample(15, 0, 2000, 0, 4095, 1'b1, 32'h0000_0020);
		add_sample(15, 1, 0, 0, 4095, 1'b1, 32'h0000_0100);
		add_sample(15, 2, 4095, 0, 4095, 1'b1, 32'h0000_0200);
		add_sample(7, 4095, 4095, 4095, 4095, 1'b0, 32'hffff_ffff);
		add_sample(3, 100, 2000, 2000, 2000, 1'b1, 100);
		add_sample(3, 101, 4095, 2000, 2000, 1'b1, 200);
		add_sample(3, 102, 0, 2000, 2000, 1'b1, 300);
		add_sample(0, 5, 4095, 4095, 0, 1'b1, 0);
		add_sample(0, 6, 1000, 500, 3500, 1'b1, 1000);
		add_sample(0, 7, 2000, 500, 3500, 1'b1, 1500);
		add_sample(0, 8, 600, 500, 3500, 1'b1, 20000);
		add_sample(0, 9, 3600, 500, 3500, 1'b1, 21000);
		add_sample(0, 10, 1900, 500, 3500, 1'b1, 22000);
		add_sample(0, 11, 3000, 500, 3500, 1'b1, 23000);
		add_sample(0, 12, 1800, 500, 3500, 1'b1, 60000);
		add_sample(0, 13, 700, 500, 3500, 1'b1, 61000);
		random_items(200);
		drain();
		set_regs(0, 10, 1, 0, 65535);
		random_items(200);
		drain();
		set_regs(15, 11, 0, 1000, 500);
		random_items(200);
		drain();
		set_regs(10, 0, 255, 65535, 1);
		random_items(200);
		drain();
		calm = 1'b1;
		set_regs($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
			$urandom_range(0, 8000), $urandom_range(0, 65535));
		random_items(200);
		drain();
		calm = 1'b0;
		set_regs(3, 7, 12, 200, 20000);
		random_items(200);
		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

>>> hall_key_press_velocity_tracker.f
rtl/hkv_pkg.sv
rtl/hkv_fifo.sv
rtl/hkv_front.sv
rtl/hkv_div.sv
rtl/hkv_back.sv
rtl/hall_key_press_velocity_tracker.sv
tb/tb.sv
